// ===== hw/rtl/rft_pkg.sv =====
// Shared types, event codes and byte classes for the revision file tokenizer.
`timescale 1ns / 1ps
`default_nettype none

package rft_pkg;

    localparam int unsigned LINE_W = 24;
    localparam int unsigned COL_W  = 16;
    localparam int unsigned TDATA_W = 56;

    localparam logic [LINE_W-1:0] LINE_TOP = '1;
    localparam logic [COL_W-1:0]  COL_TOP  = '1;

    localparam logic [2:0] EV_TEXT    = 3'd0;
    localparam logic [2:0] EV_END     = 3'd1;
    localparam logic [2:0] EV_COLON   = 3'd2;
    localparam logic [2:0] EV_SEMI    = 3'd3;
    localparam logic [2:0] EV_EOF     = 3'd4;
    localparam logic [2:0] EV_UNTERM  = 3'd5;
    localparam logic [2:0] EV_INVALID = 3'd6;

    localparam logic [1:0] KIND_NUM = 2'd0;
    localparam logic [1:0] KIND_ID  = 2'd1;
    localparam logic [1:0] KIND_STR = 2'd2;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef struct packed {
        logic [2:0]        ev;
        logic [7:0]        text;
        logic [1:0]        kind;
        logic [LINE_W-1:0] line;
        logic [COL_W-1:0]  col;
        logic              last;
    } result_t;

    function automatic logic num_class(input logic [7:0] c);
        num_class = (c inside {[8'h30:8'h39]}) || (c == CH_DOT);
    endfunction

    function automatic logic visible_class(input logic [7:0] c);
        visible_class = ((c inside {[8'h21:8'h7E]}) &&
                         !(c inside {CH_DOLLAR, CH_COMMA, CH_DOT, CH_COLON,
                                     CH_SEMI, CH_AT})) ||
                        (c inside {[8'hA0:8'hFF]});
    endfunction

    function automatic logic space_class(input logic [7:0] c);
        space_class = c inside {[8'h08:8'h0D], 8'h20};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/revision_file_tokenizer.sv =====
// Top level of the revision file tokenizer: byte decode, scan state and result queue.
//
// Usage:
//   Input channel s_axis_*: one request per byte; s_axis_tuser high marks end of
//   input instead of a byte. Output channel m_axis_*: one request per result;
//   m_axis_tuser carries the event code, m_axis_tlast marks the last result
//   caused by one input request.
//   A result passes the input register, then the four-entry result queue.
//   Throughput: one input request per cycle while at least two queue entries
//   are free. A byte that ends a token and starts another thing gives two
//   results; the result queue absorbs the burst, and input stalls only when
//   fewer than two queue entries are free.
//   Reset clears the scan state to idle, line to one, column to zero and
//   empties the input register and the result queue.
//   When the receiver stalls, the queue fills, the input register holds its
//   byte and s_axis_tready drops; nothing is lost and the output request holds.
//   After an unterminated string or an invalid character every later input
//   repeats that error until reset.
`timescale 1ns / 1ps
`default_nettype none

module revision_file_tokenizer (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [7:0]                 s_axis_tdata,   // [7:0] in_byte
    input  logic                       s_axis_tuser,   // [0] end_of_input
    output logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    // [7:0] text_byte, [9:8] token_kind, [33:10] start_line,
    // [49:34] start_column, [55:50] zero
    output logic [rft_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [2:0]                 m_axis_tuser,   // [2:0] event_res
    output logic                       m_axis_tlast
);
    import rft_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NUM,
        ST_IDENT,
        ST_STR,
        ST_STR_AT,
        ST_ERR_UNTERM,
        ST_ERR_INVALID
    } st_t;

    logic              in_valid_reg;
    logic [7:0]        byte_reg;
    logic              eof_reg;
    st_t               state_reg, state_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] tok_line_reg, tok_line_next;
    logic [COL_W-1:0]  tok_col_reg, tok_col_next;

    result_t           q_reg [4];
    logic [1:0]        wr_ptr_reg;
    logic [1:0]        rd_ptr_reg;
    logic [2:0]        count_reg;

    logic              fire;
    logic              pop;
    logic              load;
    logic [1:0]        n_res;
    result_t           res0, res1;

    logic              bt_emit;
    logic              bt_mark;
    logic [2:0]        bt_ev;
    st_t               bt_state;
    result_t           bt_res;
    result_t           head;

    assign fire          = in_valid_reg && (count_reg <= 3'd2);
    assign s_axis_tready = !in_valid_reg || fire;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (count_reg != 3'd0);
    assign pop           = m_axis_tvalid && m_axis_tready;

    assign head          = q_reg[rd_ptr_reg];
    assign m_axis_tdata  = {6'd0, head.col, head.line, head.kind, head.text};
    assign m_axis_tuser  = head.ev;
    assign m_axis_tlast  = head.last;

    // between-token decode of the held byte
    always_comb
    begin
        bt_emit  = 1'b1;
        bt_mark  = 1'b1;
        bt_state = ST_IDLE;
        bt_ev    = EV_TEXT;
        if (space_class(byte_reg))
        begin
            bt_emit = 1'b0;
            bt_mark = 1'b0;
        end
        else if (byte_reg == CH_COLON)
        begin
            bt_ev   = EV_COLON;
            bt_mark = 1'b0;
        end
        else if (byte_reg == CH_SEMI)
        begin
            bt_ev   = EV_SEMI;
            bt_mark = 1'b0;
        end
        else if (byte_reg == CH_AT)
        begin
            bt_emit  = 1'b0;
            bt_state = ST_STR;
        end
        else if (num_class(byte_reg))
        begin
            bt_state = ST_NUM;
        end
        else if (visible_class(byte_reg))
        begin
            bt_state = ST_IDENT;
        end
        else
        begin
            bt_state = ST_ERR_INVALID;
            bt_ev    = EV_INVALID;
        end
    end

    always_comb
    begin
        logic       fin;
        logic [1:0] fin_kind;
        result_t    text_res;

        fin           = 1'b0;
        fin_kind      = KIND_NUM;
        n_res         = 2'd0;
        res0          = '0;
        res1          = '0;
        state_next    = state_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;

        if (state_reg == ST_ERR_UNTERM || state_reg == ST_ERR_INVALID)
        begin
            res0.ev   = (state_reg == ST_ERR_UNTERM) ? EV_UNTERM : EV_INVALID;
            res0.line = tok_line_reg;
            res0.col  = tok_col_reg;
            n_res     = 2'd1;
        end
        else
        begin
            if (col_reg != COL_TOP)
            begin
                col_next = col_reg + 1'b1;
            end
            if (!eof_reg && byte_reg == CH_LF)
            begin
                if (line_reg != LINE_TOP)
                begin
                    line_next = line_reg + 1'b1;
                end
                col_next = '0;
            end
        end

        bt_res      = '0;
        bt_res.ev   = bt_ev;
        bt_res.text = (bt_ev == EV_TEXT) ? byte_reg : 8'd0;
        bt_res.line = line_next;
        bt_res.col  = col_next;

        text_res      = '0;
        text_res.ev   = EV_TEXT;
        text_res.text = byte_reg;
        text_res.line = tok_line_reg;
        text_res.col  = tok_col_reg;

        case (state_reg)
            ST_ERR_UNTERM, ST_ERR_INVALID:
            begin
                state_next = state_reg;
            end
            ST_NUM:
            begin
                if (eof_reg)
                begin
                    fin = 1'b1;
                end
                else if (num_class(byte_reg))
                begin
                    res0  = text_res;
                    n_res = 2'd1;
                end
                else if (visible_class(byte_reg))
                begin
                    state_next = ST_IDENT;
                    res0       = text_res;
                    n_res      = 2'd1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            ST_IDENT:
            begin
                fin_kind = KIND_ID;
                if (!eof_reg && visible_class(byte_reg))
                begin
                    res0  = text_res;
                    n_res = 2'd1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            ST_STR:
            begin
                if (eof_reg)
                begin
                    state_next = ST_ERR_UNTERM;
                    res0       = text_res;
                    res0.ev    = EV_UNTERM;
                    res0.text  = 8'd0;
                    n_res      = 2'd1;
                end
                else if (byte_reg == CH_AT)
                begin
                    state_next = ST_STR_AT;
                end
                else
                begin
                    res0  = text_res;
                    n_res = 2'd1;
                end
            end
            ST_STR_AT:
            begin
                fin_kind = KIND_STR;
                if (!eof_reg && byte_reg == CH_AT)
                begin
                    state_next = ST_STR;
                    res0       = text_res;
                    n_res      = 2'd1;
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            default:
            begin
                if (eof_reg)
                begin
                    state_next = ST_IDLE;
                    res0.ev    = EV_EOF;
                    res0.line  = line_next;
                    res0.col   = col_next;
                    n_res      = 2'd1;
                end
                else
                begin
                    state_next = bt_state;
                    res0       = bt_res;
                    n_res      = {1'b0, bt_emit};
                    if (bt_mark)
                    begin
                        tok_line_next = line_next;
                        tok_col_next  = col_next;
                    end
                end
            end
        endcase

        if (fin)
        begin
            res0      = '0;
            res0.ev   = EV_END;
            res0.kind = fin_kind;
            res0.line = tok_line_reg;
            res0.col  = tok_col_reg;
            if (eof_reg)
            begin
                state_next = ST_IDLE;
                res1       = '0;
                res1.ev    = EV_EOF;
                res1.line  = line_next;
                res1.col   = col_next;
                n_res      = 2'd2;
            end
            else
            begin
                state_next = bt_state;
                res1       = bt_res;
                n_res      = bt_emit ? 2'd2 : 2'd1;
                if (bt_mark)
                begin
                    tok_line_next = line_next;
                    tok_col_next  = col_next;
                end
            end
        end

        if (n_res == 2'd1)
        begin
            res0.last = 1'b1;
        end
        if (n_res == 2'd2)
        begin
            res1.last = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            state_reg    <= ST_IDLE;
            line_reg     <= LINE_W'(1);
            col_reg      <= '0;
            tok_line_reg <= LINE_W'(1);
            tok_col_reg  <= '0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (load)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                state_reg    <= state_next;
                line_reg     <= line_next;
                col_reg      <= col_next;
                tok_line_reg <= tok_line_next;
                tok_col_reg  <= tok_col_next;
                wr_ptr_reg   <= wr_ptr_reg + n_res;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (fire ? {1'b0, n_res} : 3'd0) - {2'd0, pop};
        end
    end

    // hold payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= s_axis_tdata;
            eof_reg  <= s_axis_tuser;
        end
        if (fire && n_res != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= res0;
        end
        if (fire && n_res == 2'd2)
        begin
            q_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rft_checker.sv =====
// Port checker for the revision file tokenizer and its bind statement.
`timescale 1ns / 1ps
`default_nettype none

module rft_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [rft_pkg::TDATA_W-1:0] m_axis_tdata,
    input  logic [2:0]                  m_axis_tuser,
    input  logic                        m_axis_tlast
);
    import rft_pkg::*;

    a_reset_clears: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output request valid after reset");

    a_hold_request: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled output request changed");

    a_single_events_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == EV_COLON || m_axis_tuser == EV_SEMI ||
            m_axis_tuser == EV_EOF || m_axis_tuser == EV_UNTERM ||
            m_axis_tuser == EV_INVALID) |-> m_axis_tlast)
        else $error("single event not marked last");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[33:10] != '0))
        else $error("start line is zero");

    a_text_no_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != EV_END |-> (m_axis_tdata[9:8] == KIND_NUM))
        else $error("token kind set outside token end");

endmodule

bind revision_file_tokenizer rft_checker u_rft_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
